>>> hdl/hsct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_pkg
// Shared sizes, codes and beat types of the sparse histogram cell table.
// ----------------------------------------------------------------------------
package hsct_pkg;

  localparam int MAX_DIMS   = 15;
  localparam int MAX_CELLS  = 1024;
  localparam int BIN_BITS   = 8;
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam int CELL_BITS = $clog2(MAX_CELLS);
  localparam int USED_BITS = CELL_BITS + 1;
  localparam int KEY_W     = MAX_DIMS * BIN_BITS;
  localparam int DIM_BITS  = 4;
  localparam int P_BITS    = FRAC_BITS + COUNT_BITS;
  localparam int CUM_BITS  = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [USED_BITS-1:0]  CELLS_MAX = USED_BITS'(MAX_CELLS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_DRAW   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_DRAW   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_MUL,
    S_TOP,
    S_WALK,
    S_FETCH,
    S_FETCH2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [BIN_BITS-1:0]  bin_index;
    logic [FRAC_BITS-1:0] draw_fraction;
  } item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CELL_BITS-1:0]  cell_index;
    logic [COUNT_BITS-1:0] cell_count;
    logic [COUNT_BITS-1:0] total_samples;
    logic                  found;
    logic                  table_full;
  } result_t;

  typedef struct packed {
    logic                key_match;
    logic                le_mid;
    logic                lt_cur;
    logic [CUM_BITS-1:0] cur;
  } cmp_t;

endpackage

>>> hdl/hsct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/hsct_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_cmp
// Shared compare unit: key row match and draw midpoint / cumulative tests.
// ----------------------------------------------------------------------------
module hsct_cmp (
  input  logic [hsct_pkg::KEY_W-1:0]      row,
  input  logic [hsct_pkg::KEY_W-1:0]      key,
  input  logic [hsct_pkg::DIM_BITS-1:0]   dims,
  input  logic [hsct_pkg::P_BITS-1:0]     p,
  input  logic [hsct_pkg::CUM_BITS-1:0]   prev,
  input  logic [hsct_pkg::COUNT_BITS-1:0] count,
  output hsct_pkg::cmp_t                  res
);

  localparam int MID_W = hsct_pkg::CUM_BITS + 1 + hsct_pkg::FRAC_BITS;

  logic [hsct_pkg::MAX_DIMS-1:0] hit;
  logic [hsct_pkg::CUM_BITS-1:0] cur;
  logic [MID_W-1:0]              mid;
  logic [MID_W-1:0]              two_p;
  logic [MID_W-1:0]              cur_s;

  always_comb begin
    for (int d = 0; d < hsct_pkg::MAX_DIMS; d++) begin
      hit[d] = (d >= int'(dims)) ||
               (row[d*hsct_pkg::BIN_BITS +: hsct_pkg::BIN_BITS] ==
                key[d*hsct_pkg::BIN_BITS +: hsct_pkg::BIN_BITS]);
    end
  end

  assign cur   = prev + hsct_pkg::CUM_BITS'(count);
  assign mid   = {(MID_W - hsct_pkg::FRAC_BITS)'(prev) +
                  (MID_W - hsct_pkg::FRAC_BITS)'(cur), {hsct_pkg::FRAC_BITS{1'b0}}};
  assign two_p = MID_W'({p, 1'b0});
  assign cur_s = MID_W'({cur, {hsct_pkg::FRAC_BITS{1'b0}}});

  assign res.key_match = &hit;
  assign res.le_mid    = two_p <= mid;
  assign res.lt_cur    = MID_W'(p) < cur_s;
  assign res.cur       = cur;

endmodule

>>> hdl/sparse_histogram_cell_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_histogram_cell_table
// Sparse table of histogram cells with insert, query, draw and clear.
// ----------------------------------------------------------------------------
// usage:
//   item beats (valid/ready) carry an op; insert and query beats each bring
//   one bin index, and a key completes on the dim_count-th beat. partial key
//   beats give no result. res beats carry one result for
//   each completed key, draw and clear.
//   insert/query scan the stored cells, one stored cell per cycle
//   through the key and count RAM read port; draw runs a multiply,
//   top test, cumulative walk and count fetch; clear and an empty
//   draw go straight to the result. the block takes one item at a time.
//   a finished result sits in the output register; a new item is taken
//   while it waits, but the next result holds until the receiver takes it.
//   cfg_we writes dim_count and restarts the key being assembled.
//   reset empties the table through its fill count, so there is no
//   clearing pass; dim_count returns to 1.
// ----------------------------------------------------------------------------
module sparse_histogram_cell_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hsct_pkg::DIM_BITS-1:0]   cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  hsct_pkg::item_t                 item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output hsct_pkg::result_t               res
);

  localparam int CB = hsct_pkg::CELL_BITS;
  localparam int UB = hsct_pkg::USED_BITS;
  localparam int NB = hsct_pkg::COUNT_BITS;
  localparam int BB = hsct_pkg::BIN_BITS;

  hsct_pkg::state_t state, state_next;

  logic [hsct_pkg::DIM_BITS-1:0] dim_count;
  logic [hsct_pkg::DIM_BITS-1:0] dims;
  logic [hsct_pkg::DIM_BITS-1:0] element_counter;
  logic [BB-1:0]                 key_buffer [hsct_pkg::MAX_DIMS];
  logic [hsct_pkg::KEY_W-1:0]    key_vec;
  logic [UB-1:0]                 cells_used;
  logic [NB-1:0]                 sample_total;
  logic                          op_query;
  logic [hsct_pkg::FRAC_BITS-1:0] frac;
  logic [hsct_pkg::P_BITS-1:0]   p;
  logic [hsct_pkg::CUM_BITS-1:0] prev;

  logic [UB-1:0] scan_addr;
  logic          rd_vld;
  logic [CB-1:0] rd_idx;
  logic          issue;
  logic          hit;
  logic [CB-1:0] hit_idx;
  logic [NB-1:0] hit_cnt;
  logic [CB-1:0] ans;

  logic                   fin;
  hsct_pkg::result_t      pend;
  hsct_pkg::result_t      pend_init;
  hsct_pkg::result_t      res_next;
  logic                   key_done;
  logic [4:0]             count_plus;

  logic                   key_we, cnt_we;
  logic [CB-1:0]          waddr, raddr;
  logic [hsct_pkg::KEY_W-1:0] key_wdata, key_rdata;
  logic [NB-1:0]          cnt_wdata, cnt_rdata;
  hsct_pkg::cmp_t         cmp;

  logic item_beat;
  logic sat;

  assign dims       = (dim_count == '0) ? hsct_pkg::DIM_BITS'(1) : dim_count;
  assign item_beat  = item_valid && item_ready;
  assign count_plus = 5'(element_counter) + 5'd1;
  assign key_done   = count_plus >= 5'(dims);
  assign issue      = scan_addr < cells_used;
  assign sat        = (sample_total == hsct_pkg::COUNT_MAX) ||
                      (hit && hit_cnt == hsct_pkg::COUNT_MAX);

  always_comb begin
    for (int d = 0; d < hsct_pkg::MAX_DIMS; d++) begin
      key_vec[d*BB +: BB]   = key_buffer[d];
      key_wdata[d*BB +: BB] = (d < int'(dims)) ? key_buffer[d] : '0;
    end
  end

  // pending beat as started by the op, and the beat as it leaves
  always_comb begin
    pend_init = '0;
    case (item.op)
      hsct_pkg::OP_CLEAR: pend_init.kind = hsct_pkg::KIND_CLEAR;
      hsct_pkg::OP_DRAW:  pend_init.kind = hsct_pkg::KIND_DRAW;
      default:            pend_init.kind = hsct_pkg::KIND_INSERT;
    endcase
    res_next               = pend;
    res_next.total_samples = sample_total;
  end

  hsct_ram #(.WIDTH(hsct_pkg::KEY_W), .DEPTH(hsct_pkg::MAX_CELLS)) u_keys (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rdata)
  );

  hsct_ram #(.WIDTH(NB), .DEPTH(hsct_pkg::MAX_CELLS)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(raddr), .rdata(cnt_rdata)
  );

  hsct_cmp u_cmp (
    .row(key_rdata), .key(key_vec), .dims(dims), .p(p),
    .prev(prev), .count(cnt_rdata), .res(cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hsct_pkg::S_IDLE: begin
        if (item_beat) begin
          case (item.op)
            hsct_pkg::OP_CLEAR: state_next = hsct_pkg::S_EMIT;
            hsct_pkg::OP_DRAW:
              state_next = (cells_used == '0) ? hsct_pkg::S_EMIT : hsct_pkg::S_MUL;
            default: if (key_done) state_next = hsct_pkg::S_SCAN;
          endcase
        end
      end
      hsct_pkg::S_SCAN: begin
        if ((rd_vld && cmp.key_match) || (!issue && !rd_vld)) begin
          state_next = hsct_pkg::S_UPD;
        end
      end
      hsct_pkg::S_UPD:  state_next = hsct_pkg::S_EMIT;
      hsct_pkg::S_MUL:  state_next = hsct_pkg::S_TOP;
      hsct_pkg::S_TOP: begin
        if (p >= {sample_total, {hsct_pkg::FRAC_BITS{1'b0}}}) begin
          state_next = hsct_pkg::S_FETCH;
        end else begin
          state_next = hsct_pkg::S_WALK;
        end
      end
      hsct_pkg::S_WALK: begin
        if (fin || (!issue && !rd_vld)) state_next = hsct_pkg::S_FETCH;
      end
      hsct_pkg::S_FETCH:  state_next = hsct_pkg::S_FETCH2;
      hsct_pkg::S_FETCH2: state_next = hsct_pkg::S_EMIT;
      hsct_pkg::S_EMIT: begin
        if (!res_valid || res_ready) state_next = hsct_pkg::S_IDLE;
      end
      default: state_next = hsct_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    waddr      = hit_idx;
    cnt_wdata  = hit_cnt + NB'(1);
    raddr      = scan_addr[CB-1:0];
    unique case (state)
      hsct_pkg::S_IDLE: item_ready = 1'b1;
      hsct_pkg::S_UPD: begin
        if (!op_query && !sat) begin
          if (hit) begin
            cnt_we = 1'b1;
          end else if (cells_used != hsct_pkg::CELLS_MAX) begin
            key_we    = 1'b1;
            cnt_we    = 1'b1;
            waddr     = cells_used[CB-1:0];
            cnt_wdata = NB'(1);
          end
        end
      end
      hsct_pkg::S_FETCH: raddr = ans;
      default: ;
    endcase
  end

  // draw walk decision for the cell now on the read port
  always_comb begin
    fin = 1'b0;
    if (rd_vld) begin
      if (rd_idx == '0) begin
        fin = cmp.lt_cur;
      end else begin
        fin = cmp.le_mid || cmp.lt_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= hsct_pkg::S_IDLE;
      dim_count       <= hsct_pkg::DIM_BITS'(1);
      element_counter <= '0;
      cells_used      <= '0;
      sample_total    <= '0;
      res_valid       <= 1'b0;
      rd_vld          <= 1'b0;
      scan_addr       <= '0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready && state != hsct_pkg::S_EMIT) res_valid <= 1'b0;
      if (cfg_we) begin
        dim_count       <= cfg_data;
        element_counter <= '0;
      end
      unique case (state)
        hsct_pkg::S_IDLE: begin
          scan_addr <= '0;
          rd_vld    <= 1'b0;
          prev      <= '0;
          hit       <= 1'b0;
          frac      <= item.draw_fraction;
          pend      <= pend_init;
          if (item_beat) begin
            case (item.op)
              hsct_pkg::OP_CLEAR: begin
                cells_used      <= '0;
                sample_total    <= '0;
                element_counter <= '0;
              end
              hsct_pkg::OP_DRAW: ;
              default: begin
                key_buffer[element_counter] <= item.bin_index;
                op_query <= (item.op == hsct_pkg::OP_QUERY);
                element_counter <= key_done ? '0 : count_plus[hsct_pkg::DIM_BITS-1:0];
              end
            endcase
          end
        end
        hsct_pkg::S_SCAN: begin
          rd_vld <= issue;
          rd_idx <= scan_addr[CB-1:0];
          if (issue) scan_addr <= scan_addr + UB'(1);
          if (rd_vld && cmp.key_match) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
            hit_cnt <= cnt_rdata;
          end
        end
        hsct_pkg::S_UPD: begin
          if (op_query) begin
            pend.kind       <= hsct_pkg::KIND_QUERY;
            pend.found      <= hit;
            pend.cell_index <= hit ? hit_idx : '0;
            pend.cell_count <= hit ? hit_cnt : '0;
          end else begin
            pend.kind <= hsct_pkg::KIND_INSERT;
            if (hit) begin
              pend.found      <= 1'b1;
              pend.cell_index <= hit_idx;
              if (sat) begin
                pend.table_full <= 1'b1;
                pend.cell_count <= hit_cnt;
              end else begin
                pend.cell_count <= hit_cnt + NB'(1);
                sample_total    <= sample_total + NB'(1);
              end
            end else if (sat || cells_used == hsct_pkg::CELLS_MAX) begin
              pend.table_full <= 1'b1;
            end else begin
              pend.cell_index <= cells_used[CB-1:0];
              pend.cell_count <= NB'(1);
              cells_used      <= cells_used + UB'(1);
              sample_total    <= sample_total + NB'(1);
            end
          end
        end
        hsct_pkg::S_MUL: begin
          p <= hsct_pkg::P_BITS'(frac) * hsct_pkg::P_BITS'(sample_total);
        end
        hsct_pkg::S_TOP: begin
          if (p >= {sample_total, {hsct_pkg::FRAC_BITS{1'b0}}}) begin
            ans <= CB'(cells_used - UB'(1));
          end else begin
            ans <= '0;
          end
        end
        hsct_pkg::S_WALK: begin
          rd_vld <= issue && !fin;
          rd_idx <= scan_addr[CB-1:0];
          if (issue) scan_addr <= scan_addr + UB'(1);
          if (rd_vld) begin
            prev <= cmp.cur;
            if (rd_idx != '0 && cmp.le_mid) begin
              ans <= rd_idx - CB'(1);
            end else if (cmp.lt_cur) begin
              ans <= rd_idx;
            end
          end
        end
        hsct_pkg::S_FETCH2: begin
          pend.found      <= 1'b1;
          pend.cell_index <= ans;
          pend.cell_count <= cnt_rdata;
        end
        hsct_pkg::S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res       <= res_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/hsct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsct_checker
// Port-level checks of the histogram cell table, bound to the top level.
// ----------------------------------------------------------------------------
module hsct_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input hsct_pkg::result_t res
);

  // a dropped sample only ever comes from an insert
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.table_full |-> res.kind == hsct_pkg::KIND_INSERT)
    else $error("table_full on a non-insert beat");

  // misses of query and draw report an empty cell
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found && res.kind != hsct_pkg::KIND_INSERT |->
      res.cell_count == '0 && res.cell_index == '0)
    else $error("miss beat carries a cell");

  // a clear leaves no samples behind
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == hsct_pkg::KIND_CLEAR |->
      res.total_samples == '0 && !res.found)
    else $error("clear beat shows samples");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

endmodule

bind sparse_histogram_cell_table hsct_checker u_hsct_checker (
  .clk(clk), .rst(rst), .res_valid(res_valid), .res_ready(res_ready), .res(res)
);
